// File: rtl/knn_pkg.sv
// Shared constants and types of the k-nearest-neighbor sorted list.
// No dependencies; imported by k_nearest_neighbor_list and the bench.
package knn_pkg;

  // List depth and coordinate width.
  localparam int unsigned NEIGHBORS      = 16;
  localparam int unsigned COORD_BITS     = 20;

  // Fixed field widths.
  localparam int unsigned DIST_BITS      = 42;
  localparam int unsigned ID_BITS        = 24;
  localparam int unsigned OP_BITS        = 2;
  localparam int unsigned ENTRY_IDX_BITS = 4;
  localparam int unsigned MAX_DUMP       = 16;

  // Derived sizes.
  localparam int unsigned IDX_BITS   = $clog2(NEIGHBORS);
  localparam int unsigned DUMP_COUNT = (NEIGHBORS < MAX_DUMP) ? NEIGHBORS : MAX_DUMP;
  localparam int unsigned MAG_BITS   = COORD_BITS + 1;
  localparam int unsigned SQ_BITS    = 2 * MAG_BITS;
  localparam int unsigned SUM_BITS   = SQ_BITS + 2;
  localparam int unsigned WIDE_BITS  = (SUM_BITS > DIST_BITS) ? SUM_BITS : DIST_BITS;

  // Stream payload widths, padded to whole bytes.
  localparam int unsigned IN_FIELD_BITS  = 6 * COORD_BITS + 2 * ID_BITS;
  localparam int unsigned IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_FIELD_BITS = 2 * DIST_BITS + ENTRY_IDX_BITS + ID_BITS + 2;
  localparam int unsigned OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  localparam logic [DIST_BITS-1:0] DIST_MAX        = {DIST_BITS{1'b1}};
  localparam logic [DIST_BITS-1:0] INIT_DIST_RESET = 42'd3298534883328;

  // Operation codes carried in tuser.
  localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_BITS-1:0] OP_OFFER = 2'd1;
  localparam logic [OP_BITS-1:0] OP_DUMP  = 2'd2;

  // Input item; the last field sits in the lowest bits.
  typedef struct packed {
    logic        [ID_BITS-1:0]    cand_id;
    logic signed [COORD_BITS-1:0] cand_z;
    logic signed [COORD_BITS-1:0] cand_y;
    logic signed [COORD_BITS-1:0] cand_x;
    logic        [ID_BITS-1:0]    query_id;
    logic signed [COORD_BITS-1:0] query_z;
    logic signed [COORD_BITS-1:0] query_y;
    logic signed [COORD_BITS-1:0] query_x;
  } knn_item_t;

  // Result item without the last flag; the last field sits in the lowest bits.
  typedef struct packed {
    logic                      entry_valid;
    logic [ID_BITS-1:0]        entry_id;
    logic [DIST_BITS-1:0]      entry_dist_sq;
    logic [ENTRY_IDX_BITS-1:0] entry_index;
    logic [DIST_BITS-1:0]      worst_dist_sq;
    logic                      accepted;
  } knn_result_t;

endpackage

// File: rtl/k_nearest_neighbor_list.sv
// Sorted list of the nearest neighbors of one query particle, with a shared
// squaring unit and a single comparator stepped by a small sequencer.
// Depends on knn_pkg.
//
// Channel   Direction  Handshake                      Contents
// s_axis    in         s_axis_tvalid / s_axis_tready  tuser op, tdata positions and ids
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata result fields, tlast
// cfg       in         cfg_we_i                       init_dist_sq
//
// Clear writes one list entry per cycle, then emits its result.
// Offer computes the distance (one axis squared per cycle on the shared
// multiplier), scans the ids, decides, makes up to NEIGHBORS insertion
// steps and then emits its result.
// Dump gives one result per cycle while the output is taken.
// Reset loads all list distances with all ones and marks every entry empty.
// The input is ready only between items; a stalled output holds the sequencer.
module k_nearest_neighbor_list (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [knn_pkg::DIST_BITS-1:0]        cfg_wdata_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // query_x, query_y, query_z, query_id, cand_x, cand_y, cand_z, cand_id
  input  logic [knn_pkg::IN_DATA_BITS-1:0]     s_axis_tdata,
  // op
  input  logic [knn_pkg::OP_BITS-1:0]          s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // accepted, worst_dist_sq, entry_index, entry_dist_sq, entry_id, entry_valid
  output logic [knn_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata,
  output logic                                 m_axis_tlast
);
  import knn_pkg::*;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CLEAR  = 3'd1;
  localparam logic [2:0] ST_DIST   = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_DECIDE = 3'd4;
  localparam logic [2:0] ST_INS    = 3'd5;
  localparam logic [2:0] ST_EMIT   = 3'd6;
  localparam logic [2:0] ST_DUMP   = 3'd7;

  // Distance step counter: axes enter on steps 0 to 2, the sum is done after step 4.
  localparam logic [2:0] CNT_AXIS_Y = 3'd1;
  localparam logic [2:0] CNT_ACC    = 3'd2;
  localparam logic [2:0] CNT_LAST   = 3'd4;

  localparam logic [IDX_BITS-1:0] IDX_LAST  = IDX_BITS'(NEIGHBORS - 1);
  localparam logic [IDX_BITS-1:0] DUMP_LAST = IDX_BITS'(DUMP_COUNT - 1);

  logic [2:0]           state_q, state_d;
  logic [IDX_BITS-1:0]  ptr_q, ptr_d;
  logic [2:0]           cnt_q, cnt_d;
  logic                 hit_q, hit_d;
  logic                 acc_flag_q, acc_flag_d;
  logic [DIST_BITS-1:0] init_q;
  knn_item_t            item_q;

  logic [MAG_BITS-1:0]  mag_q;
  logic [SQ_BITS-1:0]   prod_q;
  logic [SUM_BITS-1:0]  acc_q;

  logic [DIST_BITS-1:0] list_dist_q [NEIGHBORS];
  logic [ID_BITS-1:0]   list_id_q   [NEIGHBORS];
  logic [NEIGHBORS-1:0] list_valid_q;

  logic                 out_valid_q;
  knn_result_t          out_q;
  logic                 out_last_q;

  logic                 in_xfer;
  logic                 out_load;
  logic [IDX_BITS-1:0]  rd_idx;
  logic [DIST_BITS-1:0] rd_dist;
  logic [ID_BITS-1:0]   rd_id;
  logic                 rd_valid;
  logic                 gt;
  logic [DIST_BITS-1:0] dist_sat;
  logic [WIDE_BITS-1:0] acc_wide;
  logic signed [COORD_BITS-1:0] axis_q_c, axis_c_c;
  logic signed [MAG_BITS-1:0]   diff;
  logic [MAG_BITS-1:0]  mag_d;
  logic [SQ_BITS-1:0]   sq;

  logic                 wr_en;
  logic [IDX_BITS-1:0]  wr_idx;
  logic [DIST_BITS-1:0] wr_dist;
  logic [ID_BITS-1:0]   wr_id;
  logic                 wr_valid;
  knn_result_t          res_d;
  logic                 res_last_d;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_load      = ((state_q == ST_EMIT) || (state_q == ST_DUMP)) &&
                         (!out_valid_q || m_axis_tready);

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= INIT_DIST_RESET;
    end else if (cfg_we_i) begin
      init_q <= cfg_wdata_i;
    end
  end

  // Captured item.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= knn_item_t'(s_axis_tdata[IN_FIELD_BITS-1:0]);
    end
  end

  // Shared squaring unit: one axis difference, one square and one add per cycle.
  always_comb begin
    case (cnt_q)
      3'd0: begin
        axis_q_c = item_q.query_x;
        axis_c_c = item_q.cand_x;
      end
      CNT_AXIS_Y: begin
        axis_q_c = item_q.query_y;
        axis_c_c = item_q.cand_y;
      end
      default: begin
        axis_q_c = item_q.query_z;
        axis_c_c = item_q.cand_z;
      end
    endcase
    diff  = MAG_BITS'(axis_q_c) - MAG_BITS'(axis_c_c);
    mag_d = diff[MAG_BITS-1] ? MAG_BITS'(-diff) : MAG_BITS'(diff);
  end

  assign sq = mag_q * mag_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DIST) begin
      mag_q  <= mag_d;
      prod_q <= sq;
      if (cnt_q == 3'd0) begin
        acc_q <= '0;
      end else if (cnt_q >= CNT_ACC) begin
        acc_q <= acc_q + SUM_BITS'(prod_q);
      end
    end
  end

  // Saturate the squared distance to the stored width.
  assign acc_wide = WIDE_BITS'(acc_q);
  assign dist_sat = (acc_wide > WIDE_BITS'(DIST_MAX)) ? DIST_MAX : DIST_BITS'(acc_wide);

  // Single list read port and the shared comparator.
  assign rd_idx   = (state_q == ST_INS) ? IDX_BITS'(ptr_q - 1'b1) : ptr_q;
  assign rd_dist  = list_dist_q[rd_idx];
  assign rd_id    = list_id_q[rd_idx];
  assign rd_valid = list_valid_q[rd_idx];
  assign gt       = rd_dist > dist_sat;

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    ptr_d      = ptr_q;
    cnt_d      = cnt_q;
    hit_d      = hit_q;
    acc_flag_d = acc_flag_q;
    wr_en      = 1'b0;
    wr_idx     = ptr_q;
    wr_dist    = init_q;
    wr_id      = '0;
    wr_valid   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          ptr_d      = '0;
          cnt_d      = '0;
          hit_d      = 1'b0;
          acc_flag_d = 1'b0;
          unique case (s_axis_tuser)
            OP_CLEAR: state_d = ST_CLEAR;
            OP_OFFER: state_d = ST_DIST;
            OP_DUMP:  state_d = ST_DUMP;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR: begin
        wr_en = 1'b1;
        if (ptr_q == IDX_LAST) begin
          state_d = ST_EMIT;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      ST_DIST: begin
        if (cnt_q == CNT_LAST) begin
          state_d = ST_SCAN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_SCAN: begin
        hit_d = hit_q || (rd_valid && (rd_id == item_q.cand_id));
        if (ptr_q == IDX_LAST) begin
          state_d = ST_DECIDE;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      ST_DECIDE: begin
        // The pointer rests on the last entry, so the comparator sees the worst distance.
        if (gt && (item_q.query_id != item_q.cand_id) && !hit_q) begin
          acc_flag_d = 1'b1;
          state_d    = ST_INS;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_INS: begin
        // Move the hole toward the front while the entry ahead is farther.
        wr_en = 1'b1;
        if ((ptr_q != '0) && gt) begin
          wr_dist  = rd_dist;
          wr_id    = rd_id;
          wr_valid = rd_valid;
          ptr_d    = IDX_BITS'(ptr_q - 1'b1);
        end else begin
          wr_dist  = dist_sat;
          wr_id    = item_q.cand_id;
          wr_valid = 1'b1;
          state_d  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      ST_DUMP: begin
        if (out_load) begin
          if (ptr_q == DUMP_LAST) begin
            state_d = ST_IDLE;
          end else begin
            ptr_d = ptr_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      ptr_q      <= '0;
      cnt_q      <= '0;
      hit_q      <= 1'b0;
      acc_flag_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      ptr_q      <= ptr_d;
      cnt_q      <= cnt_d;
      hit_q      <= hit_d;
      acc_flag_q <= acc_flag_d;
    end
  end

  // List storage with one write port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NEIGHBORS; i++) begin
        list_dist_q[i] <= DIST_MAX;
        list_id_q[i]   <= '0;
      end
      list_valid_q <= '0;
    end else if (wr_en) begin
      list_dist_q[wr_idx]  <= wr_dist;
      list_id_q[wr_idx]    <= wr_id;
      list_valid_q[wr_idx] <= wr_valid;
    end
  end

  // Result assembly: dump fields only in the dump state.
  always_comb begin
    res_d.accepted      = (state_q == ST_EMIT) && acc_flag_q;
    res_d.worst_dist_sq = list_dist_q[NEIGHBORS-1];
    res_d.entry_index   = '0;
    res_d.entry_dist_sq = '0;
    res_d.entry_id      = '0;
    res_d.entry_valid   = 1'b0;
    res_last_d          = 1'b1;
    if (state_q == ST_DUMP) begin
      res_d.entry_index   = ENTRY_IDX_BITS'(ptr_q);
      res_d.entry_dist_sq = rd_dist;
      res_d.entry_id      = rd_valid ? rd_id : '0;
      res_d.entry_valid   = rd_valid;
      res_last_d          = (ptr_q == DUMP_LAST);
    end
  end

  // Output register; a waiting result does not block a new input transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q      <= res_d;
      out_last_q <= res_last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_BITS'(out_q);
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  // Between items the front entry is no farther than the last entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (list_dist_q[0] <= list_dist_q[NEIGHBORS-1]))
    else $error("list out of order between items");

  // Insertion only follows an accepting decision.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INS) |-> ($past(state_q) == ST_DECIDE || $past(state_q) == ST_INS))
    else $error("insertion entered without a decision");

  // An accepted result never carries dump fields and always closes its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.accepted) |-> (!out_q.entry_valid && out_last_q))
    else $error("accepted result carries dump fields");

  // A dump result is loaded only from the dump state with the pointer in range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (state_q == ST_DUMP)) |-> (ptr_q <= DUMP_LAST))
    else $error("dump pointer past the last read-out entry");
`endif

endmodule

// File: tb/sv/tb.sv
// Self-checking bench for k_nearest_neighbor_list: clear, offer and dump transfers are
// checked against a behavioral copy of the sorted neighbor list kept in this file.
// Depends on knn_pkg and the k_nearest_neighbor_list RTL.
module tb;
  import knn_pkg::*;

  localparam logic [OP_BITS-1:0] OP_IGNORED = 2'd3;
  localparam int COORD_HI = 2 ** (COORD_BITS - 1) - 1;
  localparam int COORD_LO = -(2 ** (COORD_BITS - 1));
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES = 16 + 2 * NEIGHBORS;
  localparam int unsigned QUIET_LIMIT = 3000;

  typedef struct packed {
    logic [OP_BITS-1:0] op;
    knn_item_t          item;
  } list_op_t;

  typedef struct packed {
    logic        last;
    knn_result_t fields;
  } list_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [DIST_BITS-1:0]     cfg_wdata_i = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [IN_DATA_BITS-1:0]  s_axis_tdata = '0;
  logic [OP_BITS-1:0]       s_axis_tuser = OP_CLEAR;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;
  logic                     m_axis_tlast;

  // Behavioral copy of the list and of the radius register.
  logic [DIST_BITS-1:0] nn_dist [NEIGHBORS];
  logic [ID_BITS-1:0]   nn_id [NEIGHBORS];
  logic                 nn_valid [NEIGHBORS];
  logic [DIST_BITS-1:0] radius_sq = INIT_DIST_RESET;

  list_op_t     pending_list_ops [$];
  list_result_t due_list_results [$];
  list_op_t     offered_op;
  list_result_t want;
  knn_result_t  got;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_armed = 1'b0;
  int unsigned held_cycles = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatch_count = 0;

  k_nearest_neighbor_list dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #10 clk_i = ~clk_i;

  // Squared difference along one axis, exact in 64 bits.
  function automatic logic [63:0] axis_sq(input logic signed [COORD_BITS-1:0] a,
                                          input logic signed [COORD_BITS-1:0] b);
    longint diff;
    diff = longint'(a) - longint'(b);
    if (diff < 0) diff = -diff;
    return diff * diff;
  endfunction

  // Applies one operation to the list copy and queues the results it should produce.
  function automatic void apply_list_op(input logic [OP_BITS-1:0] op, input knn_item_t it);
    logic [63:0]          cand_dist;
    logic                 dup;
    logic [DIST_BITS-1:0] tmp_dist;
    logic [ID_BITS-1:0]   tmp_id;
    logic                 tmp_valid;
    int                   k;
    list_result_t         r;
    r = '0;
    case (op)
      OP_CLEAR: begin
        for (k = 0; k < NEIGHBORS; k++) begin
          nn_dist[k] = radius_sq;
          nn_id[k] = '0;
          nn_valid[k] = 1'b0;
        end
        r.fields.worst_dist_sq = nn_dist[NEIGHBORS-1];
        r.last = 1'b1;
        due_list_results.push_back(r);
      end
      OP_OFFER: begin
        cand_dist = axis_sq(it.query_x, it.cand_x) + axis_sq(it.query_y, it.cand_y)
                  + axis_sq(it.query_z, it.cand_z);
        if (cand_dist > DIST_MAX) cand_dist = DIST_MAX;
        dup = 1'b0;
        for (k = 0; k < NEIGHBORS; k++) begin
          if (nn_valid[k] && nn_id[k] == it.cand_id) dup = 1'b1;
        end
        // The newcomer takes the worst slot and moves up past strictly farther entries.
        if (cand_dist < nn_dist[NEIGHBORS-1] && it.query_id != it.cand_id && !dup) begin
          nn_dist[NEIGHBORS-1] = cand_dist[DIST_BITS-1:0];
          nn_id[NEIGHBORS-1] = it.cand_id;
          nn_valid[NEIGHBORS-1] = 1'b1;
          k = NEIGHBORS - 1;
          while (k > 0 && nn_dist[k-1] > nn_dist[k]) begin
            tmp_dist = nn_dist[k-1];
            tmp_id = nn_id[k-1];
            tmp_valid = nn_valid[k-1];
            nn_dist[k-1] = nn_dist[k];
            nn_id[k-1] = nn_id[k];
            nn_valid[k-1] = nn_valid[k];
            nn_dist[k] = tmp_dist;
            nn_id[k] = tmp_id;
            nn_valid[k] = tmp_valid;
            k--;
          end
          r.fields.accepted = 1'b1;
        end
        r.fields.worst_dist_sq = nn_dist[NEIGHBORS-1];
        r.last = 1'b1;
        due_list_results.push_back(r);
      end
      OP_DUMP: begin
        for (k = 0; k < DUMP_COUNT; k++) begin
          r = '0;
          r.fields.worst_dist_sq = nn_dist[NEIGHBORS-1];
          r.fields.entry_index = k[ENTRY_IDX_BITS-1:0];
          r.fields.entry_dist_sq = nn_dist[k];
          r.fields.entry_id = nn_valid[k] ? nn_id[k] : '0;
          r.fields.entry_valid = nn_valid[k];
          r.last = (k == DUMP_COUNT - 1);
          due_list_results.push_back(r);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want_v,
                                      input logic [63:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      mismatch_count++;
    end
  endfunction

  // Item source: holds each offer until its transfer, then updates the list copy.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) apply_list_op(offered_op.op, offered_op.item);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_list_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered_op = pending_list_ops.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= offered_op.op;
          s_axis_tdata <= offered_op.item;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result sink: compares every transfer with the oldest outstanding result.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_list_results.size() == 0) begin
          $error("result transfer with nothing outstanding");
          mismatch_count++;
        end else begin
          want = due_list_results.pop_front();
          got = m_axis_tdata[OUT_FIELD_BITS-1:0];
          check_field("accepted", want.fields.accepted, got.accepted);
          check_field("worst_dist_sq", want.fields.worst_dist_sq, got.worst_dist_sq);
          check_field("entry_index", want.fields.entry_index, got.entry_index);
          check_field("entry_dist_sq", want.fields.entry_dist_sq, got.entry_dist_sq);
          check_field("entry_id", want.fields.entry_id, got.entry_id);
          check_field("entry_valid", want.fields.entry_valid, got.entry_valid);
          check_field("last", want.last, m_axis_tlast);
        end
      end
      // One long hold-off lets the block back up into its input.
      if (hold_armed && held_cycles < HOLD_CYCLES) begin
        held_cycles <= held_cycles + 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic signed [COORD_BITS-1:0] any_coord();
    logic [31:0] r;
    r = $urandom;
    return r[COORD_BITS-1:0];
  endfunction

  function automatic logic signed [COORD_BITS-1:0] near_coord(
      input logic signed [COORD_BITS-1:0] c, input int span);
    int v;
    v = int'(c) + int'($urandom_range(2 * span)) - span;
    if (v > COORD_HI) v = COORD_HI;
    if (v < COORD_LO) v = COORD_LO;
    return v[COORD_BITS-1:0];
  endfunction

  function automatic knn_item_t any_item();
    knn_item_t it;
    it.query_x = any_coord();
    it.query_y = any_coord();
    it.query_z = any_coord();
    it.query_id = $urandom;
    it.cand_x = any_coord();
    it.cand_y = any_coord();
    it.cand_z = any_coord();
    it.cand_id = $urandom;
    return it;
  endfunction

  function automatic knn_item_t mk(input int qx, input int qy, input int qz, input int qid,
                                   input int cx, input int cy, input int cz, input int cid);
    knn_item_t it;
    it.query_x = qx[COORD_BITS-1:0];
    it.query_y = qy[COORD_BITS-1:0];
    it.query_z = qz[COORD_BITS-1:0];
    it.query_id = qid[ID_BITS-1:0];
    it.cand_x = cx[COORD_BITS-1:0];
    it.cand_y = cy[COORD_BITS-1:0];
    it.cand_z = cz[COORD_BITS-1:0];
    it.cand_id = cid[ID_BITS-1:0];
    return it;
  endfunction

  function automatic void queue_item(input logic [OP_BITS-1:0] op, input knn_item_t it);
    list_op_t t;
    t.op = op;
    t.item = it;
    pending_list_ops.push_back(t);
  endfunction

  // A full search: clear, offers around one query, dumps; returns the item count.
  function automatic int unsigned queue_search(input int unsigned n_offers);
    knn_item_t          it;
    logic [ID_BITS-1:0] used_ids [$];
    int                 span;
    int unsigned        k;
    int unsigned        count;
    it = any_item();
    case ($urandom_range(3))
      0: span = 16;
      1: span = 1024;
      2: span = 65536;
      default: span = 524288;
    endcase
    queue_item(OP_CLEAR, it);
    count = 1;
    for (k = 0; k < n_offers; k++) begin
      case ($urandom_range(15))
        // Same position as the last candidate: an equal distance under a new id.
        9, 10: it.cand_id = $urandom;
        // An id that may already sit in the list.
        11, 12: begin
          it.cand_x = near_coord(it.query_x, span);
          it.cand_y = near_coord(it.query_y, span);
          it.cand_z = near_coord(it.query_z, span);
          if (used_ids.size() != 0) it.cand_id = used_ids[$urandom_range(used_ids.size() - 1)];
        end
        // The query offered as its own neighbor.
        13: it.cand_id = it.query_id;
        14: begin
          it.cand_x = any_coord();
          it.cand_y = any_coord();
          it.cand_z = any_coord();
          it.cand_id = $urandom;
        end
        15: begin
          queue_item(OP_DUMP, it);
          count++;
          it.cand_id = $urandom;
        end
        default: begin
          it.cand_x = near_coord(it.query_x, span);
          it.cand_y = near_coord(it.query_y, span);
          it.cand_z = near_coord(it.query_z, span);
          it.cand_id = $urandom;
        end
      endcase
      used_ids.push_back(it.cand_id);
      queue_item(OP_OFFER, it);
      count++;
    end
    queue_item(OP_DUMP, it);
    return count + 1;
  endfunction

  // Waits until every item and result has gone through and the block has settled.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_list_ops.size() != 0 || s_axis_tvalid || due_list_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_radius(input logic [DIST_BITS-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    radius_sq = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input logic [DIST_BITS-1:0] radius, input int unsigned idle_pct,
                           input int unsigned stall_pct, input int unsigned n_items,
                           input bit squeeze);
    int unsigned added;
    knn_item_t   it;
    logic [OP_BITS-1:0] op;
    wait_drained();
    write_radius(radius);
    @(negedge clk_i);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    if (squeeze) hold_armed = 1'b1;
    added = 0;
    while (added < n_items) begin
      if ($urandom_range(9) < 8) begin
        added += queue_search($urandom_range(4, 30));
      end else begin
        // Stray items: any operation with fully random fields.
        it = any_item();
        op = $urandom_range(3);
        queue_item(op, it);
        if (op != OP_IGNORED) added++;
      end
    end
  endtask

  initial begin
    logic [63:0] wide;
    for (int k = 0; k < NEIGHBORS; k++) begin
      nn_dist[k] = DIST_MAX;
      nn_id[k] = '0;
      nn_valid[k] = 1'b0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part, on the reset radius.
    queue_item(OP_DUMP, any_item());
    // Before any clear even the farthest corner pair fits.
    queue_item(OP_OFFER, mk(COORD_LO, COORD_LO, COORD_LO, 1, COORD_HI, COORD_HI, COORD_HI, 2));
    queue_item(OP_OFFER, mk(0, 0, 0, 1, 1, 2, 3, 3));
    queue_item(OP_DUMP, any_item());
    queue_item(OP_CLEAR, any_item());
    queue_item(OP_OFFER, mk(COORD_HI, COORD_HI, COORD_HI, 24'hFFFFFF,
                            COORD_LO, COORD_LO, COORD_LO, 0));
    queue_item(OP_OFFER, mk(0, 0, 0, 5, 1, 1, 1, 5));
    queue_item(OP_OFFER, mk(0, 0, 0, 5, 1, 2, 3, 10));
    queue_item(OP_OFFER, mk(0, 0, 0, 5, -3, 2, -1, 10));
    queue_item(OP_OFFER, mk(0, 0, 0, 5, 3, -2, 1, 11));
    queue_item(OP_OFFER, mk(7, 7, 7, 5, 7, 7, 7, 12));
    queue_item(OP_OFFER, mk(-5, 0, 0, 5, 0, 0, 0, 24'hFFFFFF));
    queue_item(OP_IGNORED, any_item());
    for (int k = 0; k < 8; k++) queue_item(OP_OFFER, mk(0, 0, 0, 5, 20 - 2 * k, 0, 0, 100 + k));
    queue_item(OP_DUMP, any_item());

    // Random phases over several radii and flow-control patterns.
    run_phase(INIT_DIST_RESET, 0, 0, 90, 1'b0);
    run_phase('0, 65, 0, 30, 1'b0);
    run_phase(DIST_BITS'($urandom_range(1, 1 << 22)), 0, 65, 90, 1'b0);
    wide = {$urandom, $urandom};
    run_phase(DIST_BITS'(wide % (64'(INIT_DIST_RESET) + 64'd1)), 30, 30, 90, 1'b0);
    run_phase(DIST_BITS'($urandom), 0, 0, 70, 1'b1);
    run_phase(DIST_BITS'(1 << 20), 30, 30, 30, 1'b0);
    wait_drained();

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
